[rtl/ssu_pkg.sv]
package ssu_pkg;

  localparam int OPW = 33;   // multiplier operand width, signed
  localparam int PW  = 66;   // product width

  localparam logic signed [OPW-1:0] LOG2E_Q30 = 33'sd1549082005;
  localparam logic signed [OPW-1:0] LN2_Q30   = 33'sd744261118;
  localparam logic [31:0]           ONE_Q30   = 32'h4000_0000;

  typedef struct packed {
    logic               action;
    logic [1:0]         layer;
    logic [2:0]         head;
    logic [3:0]         channel;
    logic [3:0]         state_index;
    logic signed [31:0] x_value;
    logic [31:0]        step_size;
    logic signed [31:0] log_decay;
    logic signed [31:0] b_value;
    logic signed [31:0] c_value;
    logic signed [31:0] skip_gain;
    logic               last_state;
  } scan_req_t;

  typedef struct packed {
    logic [1:0]         out_layer;
    logic [2:0]         out_head;
    logic [3:0]         out_channel;
    logic signed [31:0] y_value;
  } scan_res_t;

  localparam logic ACT_SCAN  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // floor(2^32 / i) for the Taylor term divisors; i = 1 bypasses the multiply
  function automatic logic signed [OPW-1:0] recip(input logic [3:0] i);
    logic signed [OPW-1:0] r;
    begin
      case (i)
        4'd2:    r = 33'sd2147483648;
        4'd3:    r = 33'sd1431655765;
        4'd4:    r = 33'sd1073741824;
        4'd5:    r = 33'sd858993459;
        4'd6:    r = 33'sd715827882;
        4'd7:    r = 33'sd613566756;
        4'd8:    r = 33'sd536870912;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    begin
      if (v > 67'sd2147483647)       r = 32'sh7FFF_FFFF;
      else if (v < -67'sd2147483648) r = 32'sh8000_0000;
      else                           r = v[31:0];
      return r;
    end
  endfunction

endpackage

[rtl/ssu_mul.sv]
module ssu_mul import ssu_pkg::*; (
  input  logic                  clk,
  input  logic signed [OPW-1:0] a,
  input  logic signed [OPW-1:0] b,
  output logic signed [PW-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[rtl/ssu_mem.sv]
module ssu_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic signed [31:0]  wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output logic signed [31:0]  rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/selective_state_scan_unit.sv]
// Selective state scan unit.
// Request channel (req_valid/req_stall/req): one scan item or a clear action.
// Result channel (res_valid/res_stall/res): one result per scan item that
// carries last_state, giving the channel output y = sum(h*c) + skip*x.
// A scan item holds req_stall high from acceptance until it is done; an
// item with last_state also has its result registered at the end.
// Its length is set by the single shared 33x33 multiplier: two exponentials,
// each a range reduction plus eight Taylor terms with a reciprocal multiply
// per term, then six dependent products for the state update and output.
// A clear action, and reset, sweep the state memory one entry per cycle
// over LAYERS*HEADS*HEAD_DIM*STATE_DIM entries (8192 by default), while
// req_stall stays high; the accumulator is zeroed at once.
// A held result (res_stall high) is kept in the output register; the unit
// goes on with the next request, and only a following result waits for it.
// Reset is synchronous, active high.
module selective_state_scan_unit import ssu_pkg::*; #(
  parameter int LAYERS    = 4,
  parameter int HEADS     = 8,
  parameter int HEAD_DIM  = 16,
  parameter int STATE_DIM = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  scan_req_t req,
  output logic      res_valid,
  input  logic      res_stall,
  output scan_res_t res
);

  localparam int DEPTH = LAYERS * HEADS * HEAD_DIM * STATE_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SH    = FRAC_BITS + 30;
  localparam int KW    = PW - SH;
  localparam int GW    = PW - FRAC_BITS;

  typedef enum logic [18:0] {
    S_CLR    = 19'h00001,
    S_IDLE   = 19'h00002,
    S_EXP_T  = 19'h00004,
    S_EXP_K  = 19'h00008,
    S_EXP_Y  = 19'h00010,
    S_TERM_M = 19'h00020,
    S_TERM_D = 19'h00040,
    S_TERM_Q = 19'h00080,
    S_EXP_S  = 19'h00100,
    S_G_M    = 19'h00200,
    S_G_C    = 19'h00400,
    S_B_M    = 19'h00800,
    S_B_C    = 19'h01000,
    S_DH_C   = 19'h02000,
    S_HN_C   = 19'h04000,
    S_ACC_M  = 19'h08000,
    S_ACC_C  = 19'h10000,
    S_Y_C    = 19'h20000,
    S_EMIT   = 19'h40000
  } state_t;

  state_t state;

  scan_req_t             cur;
  logic                  inside_r;
  logic [AW-1:0]         addr_r;
  logic [AW-1:0]         cnt;
  logic signed [OPW-1:0] exp_v;
  logic                  exp_sel;
  logic signed [KW-1:0]  k;
  logic [29:0]           yq;
  logic [30:0]           term;
  logic [31:0]           esum;
  logic [3:0]            idx;
  logic [29:0]           pq;
  logic [31:0]           exp_res;
  logic signed [31:0]    bbar;
  logic signed [PW-1:0]  dh;
  logic signed [31:0]    hn;
  logic signed [31:0]    acc;
  logic signed [31:0]    y_hold;

  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  sh_prod;
  logic signed [31:0]    rdata;
  logic signed [31:0]    h_cur;

  logic                  accept;
  logic [31:0]           addr_full;
  logic                  in_range;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic signed [31:0]    mem_wdata;
  logic                  mem_re;
  logic                  emit_go;

  // Taylor term division correction
  logic [29:0]           q0;
  logic [33:0]           qi;
  logic [33:0]           rem;
  logic [29:0]           qn;

  // exponential scaling
  logic signed [KW:0]    s;
  logic signed [KW:0]    ns;
  logic [63:0]           up;
  logic [31:0]           exp_out;

  logic [GW-1:0]         gfull;
  logic [31:0]           gclamp;
  logic signed [31:0]    acc_sum;
  logic signed [31:0]    hn_sum;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign emit_go   = !res_valid || !res_stall;

  assign addr_full = ((32'(req.layer) * 32'(HEADS) + 32'(req.head)) * 32'(HEAD_DIM)
                      + 32'(req.channel)) * 32'(STATE_DIM) + 32'(req.state_index);
  assign in_range  = (32'(req.layer) < 32'(LAYERS)) && (32'(req.head) < 32'(HEADS))
                     && (32'(req.channel) < 32'(HEAD_DIM))
                     && (32'(req.state_index) < 32'(STATE_DIM));

  assign mem_re    = accept && (req.action == ACT_SCAN);
  assign mem_we    = (state == S_CLR) || ((state == S_ACC_M) && inside_r);
  assign mem_waddr = (state == S_CLR) ? cnt : addr_r;
  assign mem_wdata = (state == S_CLR) ? 32'sd0 : hn;

  ssu_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_full[AW-1:0]),
    .rdata (rdata)
  );

  ssu_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign h_cur   = inside_r ? rdata : 32'sd0;
  assign sh_prod = prod >>> FRAC_BITS;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_EXP_T: begin
        mul_a = exp_v;
        mul_b = LOG2E_Q30;
      end
      S_EXP_K: begin
        mul_a = {3'b000, prod[FRAC_BITS+29:FRAC_BITS]};
        mul_b = LN2_Q30;
      end
      S_TERM_M: begin
        mul_a = {2'b00, term};
        mul_b = {3'b000, yq};
      end
      S_TERM_D: begin
        mul_a = {3'b000, prod[59:30]};
        mul_b = recip(idx);
      end
      S_G_M: begin
        mul_a = {1'b0, exp_res};
        mul_b = {1'b0, cur.step_size};
      end
      S_B_M: begin
        mul_a = {1'b0, cur.step_size};
        mul_b = {cur.b_value[31], cur.b_value};
      end
      S_B_C: begin
        mul_a = {1'b0, exp_res};
        mul_b = {h_cur[31], h_cur};
      end
      S_DH_C: begin
        mul_a = {bbar[31], bbar};
        mul_b = {cur.x_value[31], cur.x_value};
      end
      S_ACC_M: begin
        mul_a = {hn[31], hn};
        mul_b = {cur.c_value[31], cur.c_value};
      end
      S_ACC_C: begin
        mul_a = {cur.skip_gain[31], cur.skip_gain};
        mul_b = {cur.x_value[31], cur.x_value};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // quotient from the reciprocal product may be one short
  always_comb begin
    q0  = prod[61:32];
    qi  = 34'(q0) * 34'(idx);
    rem = 34'(pq) - qi;
    if (idx == 4'd1) begin
      qn = pq;
    end else if (rem >= 34'(idx)) begin
      qn = q0 + 30'd1;
    end else begin
      qn = q0;
    end
  end

  // 2^k scaling of the Q30 series sum into the output format
  always_comb begin
    s       = {k[KW-1], k} - (KW+1)'(30 - FRAC_BITS);
    ns      = -s;
    up      = '0;
    exp_out = '0;
    if (s > 0) begin
      if (s >= 33) begin
        exp_out = 32'hFFFF_FFFF;
      end else begin
        up      = {32'b0, esum} << s[5:0];
        exp_out = (up[63:32] != 32'b0) ? 32'hFFFF_FFFF : up[31:0];
      end
    end else if (ns >= 32) begin
      exp_out = '0;
    end else begin
      exp_out = esum >> ns[4:0];
    end
  end

  assign gfull   = prod[PW-1:FRAC_BITS];
  assign gclamp  = (gfull > GW'(64'h8000_0000)) ? 32'h8000_0000 : gfull[31:0];
  assign hn_sum  = sat32(67'(dh) + 67'(sh_prod));
  assign acc_sum = sat32(67'(acc) + 67'(sh_prod));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      acc       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && emit_go) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_CLR: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur <= req;
            if (req.action == ACT_CLEAR) begin
              acc   <= '0;
              cnt   <= '0;
              state <= S_CLR;
            end else begin
              inside_r <= in_range;
              addr_r   <= addr_full[AW-1:0];
              exp_v    <= {req.log_decay[31], req.log_decay};
              exp_sel  <= 1'b0;
              state    <= S_EXP_T;
            end
          end
        end
        S_EXP_T: state <= S_EXP_K;
        S_EXP_K: begin
          k     <= KW'(prod >>> SH);
          state <= S_EXP_Y;
        end
        S_EXP_Y: begin
          yq    <= prod[59:30];
          term  <= ONE_Q30[30:0];
          esum  <= ONE_Q30;
          idx   <= 4'd1;
          state <= S_TERM_M;
        end
        S_TERM_M: state <= S_TERM_D;
        S_TERM_D: begin
          pq    <= prod[59:30];
          state <= S_TERM_Q;
        end
        S_TERM_Q: begin
          term <= {1'b0, qn};
          esum <= esum + 32'(qn);
          if (idx == 4'd8) begin
            state <= S_EXP_S;
          end else begin
            idx   <= idx + 4'd1;
            state <= S_TERM_M;
          end
        end
        S_EXP_S: begin
          exp_res <= exp_out;
          state   <= exp_sel ? S_B_M : S_G_M;
        end
        S_G_M: state <= S_G_C;
        S_G_C: begin
          exp_v   <= 33'sd0 - $signed({1'b0, gclamp});
          exp_sel <= 1'b1;
          state   <= S_EXP_T;
        end
        S_B_M: state <= S_B_C;
        S_B_C: begin
          bbar  <= sat32(67'(sh_prod));
          state <= S_DH_C;
        end
        S_DH_C: begin
          dh    <= sh_prod;
          state <= S_HN_C;
        end
        S_HN_C: begin
          hn    <= hn_sum;
          state <= S_ACC_M;
        end
        S_ACC_M: state <= S_ACC_C;
        S_ACC_C: begin
          acc   <= acc_sum;
          state <= cur.last_state ? S_Y_C : S_IDLE;
        end
        S_Y_C: begin
          y_hold <= acc_sum;
          acc    <= '0;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            res.out_layer   <= cur.layer;
            res.out_head    <= cur.head;
            res.out_channel <= cur.channel;
            res.y_value     <= y_hold;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
